@@ design/vrfp_pkg.sv @@
// Shared types and constants for the vision result frame parser.
// No dependencies.
package vrfp_pkg;

    localparam logic [7:0] HEADER_RESET = 8'hBB;
    localparam logic [7:0] TAIL_RESET   = 8'h55;

    localparam int         DATA_LEN     = 6;
    localparam logic [2:0] LAST_DATA    = 3'd5;    // checksum position
    localparam logic [2:0] SUM_LEN      = 3'd5;

    localparam logic       CFG_HEADER   = 1'b0;
    localparam logic       CFG_TAIL     = 1'b1;

    typedef struct packed {
        logic        frame_accepted;
        logic [7:0]  target_id;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic        result_valid;
    } t_result;

endpackage

@@ design/vrfp_parser.sv @@
// Frame parsing state: phase, data store, running sum, held result, config registers.
// Depends on vrfp_pkg.
module vrfp_parser import vrfp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    input  logic          i_accept,
    input  logic [7:0]    i_rx_byte,
    output t_result       o_result
);

    localparam logic [1:0] PH_WAIT    = 2'd0;
    localparam logic [1:0] PH_COLLECT = 2'd1;
    localparam logic [1:0] PH_TAIL    = 2'd2;

    logic [7:0]  r_header, r_tail;
    logic [1:0]  r_phase, n_phase;
    logic [2:0]  r_count, n_count;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_data [DATA_LEN];
    logic [7:0]  r_id, n_id;
    logic [15:0] r_x, n_x;
    logic [15:0] r_y, n_y;
    logic        r_have_result, n_have_result;
    logic        frame_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
            r_tail   <= TAIL_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_HEADER) begin
                r_header <= i_cfg_data;
            end else begin
                r_tail <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_count       = r_count;
        n_sum         = r_sum;
        n_id          = r_id;
        n_x           = r_x;
        n_y           = r_y;
        n_have_result = r_have_result;
        frame_ok      = 1'b0;
        case (r_phase)
            PH_WAIT: begin
                if (i_rx_byte == r_header) begin
                    n_phase = PH_COLLECT;
                    n_count = 3'd0;
                    n_sum   = 8'd0;
                end
            end
            PH_COLLECT: begin
                if (r_count < SUM_LEN) begin
                    n_sum = r_sum + i_rx_byte;
                end
                n_count = r_count + 3'd1;
                if (r_count == LAST_DATA) begin
                    n_phase = PH_TAIL;
                end
            end
            PH_TAIL: begin
                frame_ok = (i_rx_byte == r_tail) && (r_sum == r_data[5]);
                if (frame_ok) begin
                    n_id          = r_data[0];
                    n_x           = {r_data[1], r_data[2]};
                    n_y           = {r_data[3], r_data[4]};
                    n_have_result = 1'b1;
                end
                n_phase = PH_WAIT;
                n_count = 3'd0;
            end
            default: begin
                n_phase = PH_WAIT;
                n_count = 3'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_WAIT;
            r_count       <= 3'd0;
            r_sum         <= 8'd0;
            r_id          <= 8'd0;
            r_x           <= 16'd0;
            r_y           <= 16'd0;
            r_have_result <= 1'b0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_count       <= n_count;
            r_sum         <= n_sum;
            r_id          <= n_id;
            r_x           <= n_x;
            r_y           <= n_y;
            r_have_result <= n_have_result;
        end
    end

    // data store: no reset, only read after all six entries are written
    always_ff @(posedge i_clk) begin
        if (i_accept && r_phase == PH_COLLECT && r_count <= LAST_DATA) begin
            r_data[r_count] <= i_rx_byte;
        end
    end

    always_comb begin
        o_result.frame_accepted = frame_ok;
        o_result.target_id      = n_id;
        o_result.pos_x          = n_x;
        o_result.pos_y          = n_y;
        o_result.result_valid   = n_have_result;
    end

`ifndef NO_ASSERTIONS
    a_accept_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && frame_ok) |=> r_have_result)
        else $error("accepted frame did not set result valid");
    a_valid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_result |=> r_have_result)
        else $error("result valid flag dropped");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_COLLECT) |-> (r_count <= LAST_DATA))
        else $error("data count beyond frame length while collecting");
    a_tail_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_phase == PH_TAIL) |=> (r_phase == PH_WAIT))
        else $error("parser did not return to wait after tail");
`endif

endmodule

@@ design/vrfp_out_reg.sv @@
// Result register between the parser and the output channel.
// Depends on vrfp_pkg.
module vrfp_out_reg import vrfp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_result,
    output logic    o_full
);

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    // full only when the held request cannot leave this cycle
    assign o_full   = r_valid && i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ design/vision_result_frame_parser.sv @@
// Vision result frame parser: serial byte in, one result request per byte out.
// Depends on vrfp_pkg, vrfp_parser and vrfp_out_reg.
//
// Input channel: i_in_valid / o_in_stall with i_rx_byte, one received serial
// byte per request. Frames are header, id, X high, X low, Y high, Y low,
// checksum, tail. A frame passes when the tail matches and the 8-bit sum of
// the five data bytes equals the checksum.
// Output channel: o_out_valid / i_out_stall; every input byte yields exactly
// one result request carrying the held id, X, Y, the sticky valid flag and a
// pulse flag for a frame completed by this byte.
// Output valid is set in the cycle after input accept. Throughput is one
// byte per cycle while the receiver does not stall: the per-byte state
// update is short combinational logic in front of the result register.
// Configuration: i_cfg_we writes header (index 0) or tail (index 1) byte.
// Reset (synchronous, active low) restores header 0xBB, tail 0x55, clears
// the parser and the held result and empties the result register.
// When the receiver stalls, the result register holds its request and
// o_in_stall is raised until it is taken.
module vision_result_frame_parser import vrfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_frame_accepted,
    output logic [7:0]  o_target_id,
    output logic [15:0] o_pos_x,
    output logic [15:0] o_pos_y,
    output logic        o_result_valid
);

    t_result parsed;
    t_result held;
    logic    out_full;
    logic    in_accept;

    assign o_in_stall = out_full;
    assign in_accept  = i_in_valid && !out_full;

    vrfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_rx_byte   (i_rx_byte),
        .o_result    (parsed)
    );

    vrfp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_accept),
        .i_result (parsed),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_result (held),
        .o_full   (out_full)
    );

    assign o_frame_accepted = held.frame_accepted;
    assign o_target_id      = held.target_id;
    assign o_pos_x          = held.pos_x;
    assign o_pos_y          = held.pos_y;
    assign o_result_valid   = held.result_valid;

endmodule
